[sv/drc_pkg.sv]
// Shared types, codes and helpers for the dedup route cache.
package drc_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DEPTH_MAX = 64;
  localparam int CNT_W = $clog2(DEPTH_MAX + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_HIT       = 3'd3;
  localparam logic [2:0] ST_MISS      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] src_id;
    logic [7:0] dst_id;
    logic [7:0] circuit_id;
    logic       direction;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_dst;
    logic       final_result;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic             lookup;
    logic [7:0]       src_id;
    logic [7:0]       dst_id;
    logic [7:0]       circuit_id;
    logic             direction;
    logic [CNT_W-1:0] remain;
    logic             dup;
    logic             pend_valid;
    logic [7:0]       pend_dst;
  } tok_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } emit_t;

  function automatic rsp_t finish(input tok_t t, input logic at_end);
    rsp_t r;
    r.found_dst    = 8'd0;
    r.final_result = 1'b1;
    if (t.lookup) begin
      if (t.pend_valid) begin
        r.status    = ST_HIT;
        r.found_dst = t.pend_dst;
      end else begin
        r.status = ST_MISS;
      end
    end else if (t.dup) begin
      r.status = ST_DUPLICATE;
    end else if (at_end) begin
      r.status = ST_FULL;
    end else begin
      r.status = ST_INSERTED;
    end
    return r;
  endfunction

endpackage

[sv/drc_cell.sv]
// One table entry with its compare logic and the token stage to its neighbor.
module drc_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  drc_pkg::tok_t  tin,
  output drc_pkg::tok_t  tout,
  output drc_pkg::emit_t em
);

  logic [7:0] src;
  logic [7:0] dst;
  logic [7:0] circ;
  logic       dir;

  drc_pkg::tok_t tout_next;
  logic          active;
  logic          at_tail;
  logic          match_all;
  logic          match_lk;

  assign active    = tin.valid && (tin.remain != '0);
  assign at_tail   = tin.valid && (tin.remain == '0);
  assign match_lk  = (circ == tin.circuit_id) && (dir == tin.direction);
  assign match_all = match_lk && (src == tin.src_id) && (dst == tin.dst_id);

  always_comb begin
    tout_next = tin;
    em        = '0;
    if (at_tail) begin
      tout_next.valid = 1'b0;
      em.valid        = 1'b1;
      em.rsp          = drc_pkg::finish(tin, 1'b0);
    end else if (active) begin
      tout_next.remain = tin.remain - 1'b1;
      if (!tin.lookup && match_all) begin
        tout_next.dup = 1'b1;
      end
      if (tin.lookup && match_lk) begin
        tout_next.pend_valid = 1'b1;
        tout_next.pend_dst   = dst;
        if (tin.pend_valid) begin
          em.valid               = 1'b1;
          em.rsp.status          = drc_pkg::ST_HIT;
          em.rsp.found_dst       = tin.pend_dst;
          em.rsp.final_result    = 1'b0;
        end
      end
    end else begin
      tout_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else if (adv) begin
      tout <= tout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && at_tail && !tin.lookup && !tin.dup) begin
      src  <= tin.src_id;
      dst  <= tin.dst_id;
      circ <= tin.circuit_id;
      dir  <= tin.direction;
    end
  end

endmodule

[sv/dedup_route_cache.sv]
// Top level of the dedup route cache: request intake, cell row and result register.
// Stores up to TABLE_DEPTH (source, destination, circuit, direction) records in
// insertion order, one record per cell of a row of cells. An insert or lookup
// walks a token down the row one cell per cycle while the output can advance,
// over the n stored records, and the cache stays busy until its final word is
// registered; a lookup hands out non-final hit words along the way.
// A clear sets a pending flag first; an unused request code gives no word.
// One request is in flight at a time; a new request is accepted while the last
// result word still waits in the output register.
module dedup_route_cache #(
  parameter int TABLE_DEPTH = drc_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  drc_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output drc_pkg::rsp_t  rsp
);

  localparam int CW = drc_pkg::CNT_W;

  drc_pkg::tok_t  tok0;
  drc_pkg::tok_t  tok  [TABLE_DEPTH];
  drc_pkg::emit_t em   [TABLE_DEPTH];
  drc_pkg::emit_t em_all;
  logic [TABLE_DEPTH-1:0] em_vec;
  logic [TABLE_DEPTH-1:0] tok_vec;

  logic [CW-1:0] entry_count;
  logic          busy;
  logic          clr_pend;
  logic          adv;
  logic          accept;

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    drc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .tin  ((i == 0) ? tok0 : tok[(i == 0) ? 0 : i - 1]),
      .tout (tok[i]),
      .em   (em[i])
    );
    assign em_vec[i]  = em[i].valid;
    assign tok_vec[i] = tok[i].valid;
  end

  always_comb begin
    em_all = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      em_all = em_all | em[i];
    end
    if (tok[TABLE_DEPTH-1].valid) begin
      em_all.valid = 1'b1;
      em_all.rsp   = drc_pkg::finish(tok[TABLE_DEPTH-1], 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      clr_pend    <= 1'b0;
      rsp_valid   <= 1'b0;
      tok0.valid  <= 1'b0;
      entry_count <= '0;
    end else begin
      if (adv) begin
        rsp_valid  <= em_all.valid || clr_pend;
        clr_pend   <= 1'b0;
        tok0.valid <= 1'b0;
        if (clr_pend) begin
          rsp.status       <= drc_pkg::ST_CLEARED;
          rsp.found_dst    <= 8'd0;
          rsp.final_result <= 1'b1;
          entry_count      <= '0;
          busy             <= 1'b0;
        end else if (em_all.valid) begin
          rsp <= em_all.rsp;
          if (em_all.rsp.final_result) begin
            busy <= 1'b0;
          end
          if (em_all.rsp.status == drc_pkg::ST_INSERTED) begin
            entry_count <= entry_count + 1'b1;
          end
        end
      end
      if (accept) begin
        case (req.req_type)
          drc_pkg::REQ_INSERT, drc_pkg::REQ_LOOKUP: begin
            tok0.valid      <= 1'b1;
            tok0.lookup     <= (req.req_type == drc_pkg::REQ_LOOKUP);
            tok0.src_id     <= req.src_id;
            tok0.dst_id     <= req.dst_id;
            tok0.circuit_id <= req.circuit_id;
            tok0.direction  <= req.direction;
            tok0.remain     <= entry_count;
            tok0.dup        <= 1'b0;
            tok0.pend_valid <= 1'b0;
            tok0.pend_dst   <= 8'd0;
            busy            <= 1'b1;
          end
          drc_pkg::REQ_CLEAR: begin
            clr_pend <= 1'b1;
            busy     <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_one_emitter: assert property (@(posedge clk) disable iff (rst)
    $onehot0(em_vec))
    else $error("more than one cell emits a word");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_vec == '0) && !tok0.valid && !clr_pend)
    else $error("token in flight while idle");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (adv && !clr_pend && em_all.valid && em_all.rsp.status == drc_pkg::ST_INSERTED)
    |=> entry_count == $past(entry_count) + CW'(1))
    else $error("insert did not advance the entry count");
`endif

endmodule

[tb/tb_dedup_route_cache.sv]
// Self-checking testbench for dedup_route_cache: directed and random requests, predicted words.
module tb_dedup_route_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 120;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  drc_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready;
  drc_pkg::rsp_t  rsp;

  logic [7:0] route_src_m [DEPTH];
  logic [7:0] route_dst_m [DEPTH];
  logic [7:0] route_circ_m [DEPTH];
  logic       route_dir_m [DEPTH];
  int         route_count;

  drc_pkg::rsp_t reply_words [$];
  int   mismatches;
  int   quiet_cycles;
  bit   send_gaps;
  bit   recv_stalls;

  logic [7:0] circ_pool [4];
  logic [7:0] src_pool [4];
  logic [7:0] dst_pool [4];

  dedup_route_cache #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic drc_pkg::req_t make_req(input logic [1:0] kind, input logic [7:0] s,
                                             input logic [7:0] d, input logic [7:0] c,
                                             input logic dir);
    drc_pkg::req_t r;
    r.req_type   = kind;
    r.src_id     = s;
    r.dst_id     = d;
    r.circuit_id = c;
    r.direction  = dir;
    return r;
  endfunction

  function automatic drc_pkg::rsp_t make_word(input logic [2:0] st, input logic [7:0] d,
                                              input logic last);
    drc_pkg::rsp_t w;
    w.status       = st;
    w.found_dst    = d;
    w.final_result = last;
    return w;
  endfunction

  // Update the route table copy and queue the words this request should produce.
  function automatic void predict_route(input drc_pkg::req_t r);
    bit            dup;
    bit            have;
    drc_pkg::rsp_t held;
    dup  = 0;
    have = 0;
    held = '0;
    case (r.req_type)
      drc_pkg::REQ_INSERT: begin
        for (int i = 0; i < route_count; i++) begin
          if (route_src_m[i] == r.src_id && route_dst_m[i] == r.dst_id &&
              route_circ_m[i] == r.circuit_id && route_dir_m[i] == r.direction)
            dup = 1;
        end
        if (dup) begin
          reply_words.push_back(make_word(drc_pkg::ST_DUPLICATE, 8'd0, 1'b1));
        end else if (route_count >= DEPTH) begin
          reply_words.push_back(make_word(drc_pkg::ST_FULL, 8'd0, 1'b1));
        end else begin
          route_src_m[route_count]  = r.src_id;
          route_dst_m[route_count]  = r.dst_id;
          route_circ_m[route_count] = r.circuit_id;
          route_dir_m[route_count]  = r.direction;
          route_count++;
          reply_words.push_back(make_word(drc_pkg::ST_INSERTED, 8'd0, 1'b1));
        end
      end
      drc_pkg::REQ_LOOKUP: begin
        for (int i = 0; i < route_count; i++) begin
          if (route_circ_m[i] == r.circuit_id && route_dir_m[i] == r.direction) begin
            if (have) reply_words.push_back(held);
            held = make_word(drc_pkg::ST_HIT, route_dst_m[i], 1'b0);
            have = 1;
          end
        end
        if (have) begin
          held.final_result = 1'b1;
          reply_words.push_back(held);
        end else begin
          reply_words.push_back(make_word(drc_pkg::ST_MISS, 8'd0, 1'b1));
        end
      end
      drc_pkg::REQ_CLEAR: begin
        route_count = 0;
        reply_words.push_back(make_word(drc_pkg::ST_CLEARED, 8'd0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input drc_pkg::req_t r);
    int gap;
    gap = 0;
    if (send_gaps && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (!req_ready);
    predict_route(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (reply_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    drc_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (reply_words.size() == 0) begin
        $error("unexpected word: status %0d found_dst %0d final_result %0d",
               rsp.status, rsp.found_dst, rsp.final_result);
        mismatches++;
      end else begin
        want = reply_words.pop_front();
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.found_dst !== want.found_dst) begin
          $error("found_dst expected %0d actual %0d", want.found_dst, rsp.found_dst);
          mismatches++;
        end
        if (rsp.final_result !== want.final_result) begin
          $error("final_result expected %0d actual %0d", want.final_result,
                 rsp.final_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int hold;
    hold      = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (recv_stalls && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 19);
      rsp_ready = (hold == 0);
    end
  end

  task automatic test_insert();
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd255, 8'd255, 8'd255, 1'b1));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd255, 8'd255, 8'd255, 1'b1));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd0, 8'd0, 8'd0, 1'b1));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd1, 8'd0, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd0, 8'd1, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd0, 8'd0, 8'd1, 1'b0));
  endtask

  task automatic test_lookup();
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'hA5, 8'h5A, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'd0, 8'd0, 8'd255, 1'b1));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'd255, 8'd255, 8'd255, 1'b0));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'd0, 8'd0, 8'd77, 1'b1));
  endtask

  task automatic test_unused_code();
    send_request(make_req(REQ_UNUSED, 8'd255, 8'd255, 8'd255, 1'b1));
    send_request(make_req(REQ_UNUSED, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'd0, 8'd0, 8'd0, 1'b0));
  endtask

  task automatic test_clear();
    send_request(make_req(drc_pkg::REQ_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'd0, 8'd0, 8'd0, 1'b0));
    send_request(make_req(drc_pkg::REQ_CLEAR, 8'd255, 8'd255, 8'd255, 1'b1));
    send_request(make_req(drc_pkg::REQ_INSERT, 8'd9, 8'd8, 8'd7, 1'b1));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'd0, 8'd0, 8'd7, 1'b1));
  endtask

  task automatic test_full_table();
    logic [7:0] circ;
    logic       dir;
    logic [7:0] first_src;
    logic [7:0] first_dst;
    circ      = 8'($urandom);
    dir       = 1'($urandom);
    first_src = 8'($urandom);
    first_dst = 8'($urandom);
    send_request(make_req(drc_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom)));
    for (int i = 0; i < DEPTH; i++)
      send_request(make_req(drc_pkg::REQ_INSERT, i == 0 ? first_src : 8'($urandom),
                            i == 0 ? first_dst : 8'(i), circ, dir));
    wait_drained();
    send_request(make_req(drc_pkg::REQ_INSERT, 8'($urandom), 8'($urandom), circ, ~dir));
    send_request(make_req(drc_pkg::REQ_INSERT, first_src, first_dst, circ, dir));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'($urandom), 8'($urandom), circ, dir));
    send_request(make_req(drc_pkg::REQ_LOOKUP, 8'($urandom), 8'($urandom), circ, ~dir));
  endtask

  task automatic test_random();
    int         pick;
    logic [7:0] s;
    logic [7:0] d;
    logic [7:0] c;
    for (int k = 0; k < 4; k++) begin
      circ_pool[k] = 8'($urandom);
      src_pool[k]  = 8'($urandom);
      dst_pool[k]  = 8'($urandom);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 40) begin
        send_gaps   = 0;
        recv_stalls = 0;
      end
      pick = $urandom_range(0, 99);
      s = ($urandom_range(0, 4) == 0) ? 8'($urandom) : src_pool[$urandom_range(0, 3)];
      d = ($urandom_range(0, 4) == 0) ? 8'($urandom) : dst_pool[$urandom_range(0, 3)];
      c = ($urandom_range(0, 4) == 0) ? 8'($urandom) : circ_pool[$urandom_range(0, 3)];
      if (pick < 4)
        send_request(make_req(drc_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom)));
      else if (pick < 8)
        send_request(make_req(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                              1'($urandom)));
      else if (pick < 60)
        send_request(make_req(drc_pkg::REQ_INSERT, s, d, c, 1'($urandom)));
      else
        send_request(make_req(drc_pkg::REQ_LOOKUP, 8'($urandom), 8'($urandom), c,
                              1'($urandom)));
    end
  endtask

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    route_count  = 0;
    send_gaps    = 1;
    recv_stalls  = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_insert();
    test_lookup();
    test_unused_code();
    test_clear();
    test_full_table();
    wait_drained();
    test_random();
    wait_drained();
    repeat (2 * DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && reply_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/drc_pkg.sv
sv/drc_cell.sv
sv/dedup_route_cache.sv
tb/tb_dedup_route_cache.sv
